// ===== hw/rtl/sss_pkg.sv =====
// Package for the split segment stitcher: chunk item and push types, mode codes.
// No dependencies; imported by sss_step, sss_out_queue and the top level.
package sss_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned KeepW  = DataW / 8;
  localparam int unsigned CountW = $clog2(KeepW);

  // One-hot stitching modes
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_FWD1 = 4'b0010,
    MODE_FWD2 = 4'b0100,
    MODE_JOIN = 4'b1000
  } sss_mode_e;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic [KeepW-1:0] keep;
    logic             last;
  } sss_item_t;

  // Results of one input transfer: push1 is only set together with push0
  typedef struct packed {
    logic      push0;
    logic      push1;
    sss_item_t item0;
    sss_item_t item1;
  } sss_push_t;

endpackage

// ===== hw/rtl/sss_step.sv =====
// Stitching state and per-chunk logic: pass-through, first-piece end and join.
// Depends on sss_pkg; produces up to two result chunks per input transfer.
module sss_step
  import sss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [DataW-1:0] in_data_i,
  input  logic [KeepW-1:0] in_keep_i,
  input  logic             in_last_i,
  input  logic             split_flag_i,
  output sss_push_t        push_o
);

  sss_mode_e         mode_q, mode_d;
  logic              must_join_q, must_join_d;
  logic [DataW-1:0]  held_bytes_q, held_bytes_d;
  logic [KeepW-1:0]  held_valid_q, held_valid_d;
  logic [CountW-1:0] held_count_q, held_count_d;

  logic [CountW:0]   keep_ones;
  logic              eff_join;
  logic [5:0]        byte_sh;
  logic [5:0]        rem_sh;
  logic [KeepW-1:0]  bmask;
  logic [DataW-1:0]  dmask;
  logic [DataW-1:0]  join_data;
  logic [KeepW-1:0]  join_keep;
  logic [2:0]        fit_idx;
  logic              fits;
  logic [DataW-1:0]  rem_bytes;
  logic [KeepW-1:0]  rem_valid;

  always_comb begin
    keep_ones = '0;
    for (int i = 0; i < KeepW; i++) begin
      keep_ones = keep_ones + (CountW+1)'(in_keep_i[i]);
    end
  end

  // Join datapath: held bytes low, new chunk shifted in behind them
  always_comb begin
    byte_sh   = {held_count_q, 3'b000};
    rem_sh    = 6'(7'd64 - {1'b0, byte_sh});
    bmask     = 8'((9'd1 << held_count_q) - 9'd1);
    for (int i = 0; i < KeepW; i++) begin
      dmask[8*i +: 8] = {8{bmask[i]}};
    end
    join_data = (held_bytes_q & dmask) | (in_data_i << byte_sh);
    join_keep = (held_valid_q & bmask) | (in_keep_i << held_count_q);
    fit_idx   = 3'(4'd8 - {1'b0, held_count_q});
    fits      = !in_keep_i[fit_idx];
    rem_bytes = in_data_i >> rem_sh;
    rem_valid = (in_keep_i >> fit_idx) & bmask;
  end

  always_comb begin
    mode_d       = mode_q;
    must_join_d  = must_join_q;
    held_bytes_d = held_bytes_q;
    held_valid_d = held_valid_q;
    held_count_d = held_count_q;
    eff_join     = must_join_q;
    push_o       = '0;
    push_o.item0 = '{data: in_data_i, keep: in_keep_i, last: 1'b0};
    push_o.item1 = '{data: rem_bytes, keep: rem_valid, last: 1'b1};

    unique case (mode_q) inside
      MODE_IDLE, MODE_FWD1: begin
        if (mode_q == MODE_IDLE) begin
          must_join_d = split_flag_i;
          eff_join    = split_flag_i;
        end
        if (!in_last_i) begin
          push_o.push0 = 1'b1;
          mode_d       = MODE_FWD1;
        end else if (!eff_join) begin
          push_o.push0      = 1'b1;
          push_o.item0.last = 1'b1;
          mode_d            = MODE_IDLE;
        end else if (keep_ones == '0 || keep_ones == (CountW+1)'(KeepW)) begin
          // aligned or empty end of first piece: forward, second piece passes
          push_o.push0 = 1'b1;
          mode_d       = MODE_FWD2;
        end else begin
          held_bytes_d = in_data_i;
          held_valid_d = in_keep_i;
          held_count_d = CountW'(keep_ones);
          mode_d       = MODE_JOIN;
        end
      end
      MODE_FWD2: begin
        push_o.push0      = 1'b1;
        push_o.item0.last = in_last_i;
        if (in_last_i) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_JOIN: begin
        push_o.push0      = 1'b1;
        push_o.item0.data = join_data;
        push_o.item0.keep = join_keep;
        held_bytes_d      = rem_bytes;
        held_valid_d      = rem_valid;
        if (fits) begin
          push_o.item0.last = 1'b1;
          mode_d            = MODE_IDLE;
        end else if (in_last_i) begin
          // bytes left over: residue chunk follows with last
          push_o.push1 = 1'b1;
          mode_d       = MODE_IDLE;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase

    if (!in_fire_i) begin
      push_o.push0 = 1'b0;
      push_o.push1 = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      must_join_q <= 1'b0;
    end else if (in_fire_i) begin
      mode_q      <= mode_d;
      must_join_q <= must_join_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      held_bytes_q <= held_bytes_d;
      held_valid_q <= held_valid_d;
      held_count_q <= held_count_d;
    end
  end

endmodule

// ===== hw/rtl/sss_out_queue.sv =====
// Three-entry result queue taking up to two chunks per cycle, one out per cycle while out_ready_i is high.
// Depends on sss_pkg; ready is decoded from the registered count only, so the two stream sides stay decoupled.
module sss_out_queue
  import sss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sss_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sss_item_t out_item_o
);

  sss_item_t  slot_q [3];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic [1:0] wr_next;
  logic       pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign pop         = (count_q != 2'd0) && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = slot_q[rd_ptr_q];
  // Room for two chunks whatever the next transfer brings
  assign room_o      = (count_q <= 2'd1);
  assign wr_next     = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.push1) begin
      wr_ptr_d = ptr_inc(wr_next);
    end else if (push_i.push0) begin
      wr_ptr_d = wr_next;
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + 2'(push_i.push0) + 2'(push_i.push1) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      slot_q[wr_ptr_q] <= push_i.item0;
    end
    if (push_i.push1) begin
      slot_q[wr_next] <= push_i.item1;
    end
  end

endmodule

// ===== hw/rtl/split_segment_stitcher_core.sv =====
// Split segment stitcher top level: joins the two pieces of a wrapped segment.
// Depends on sss_pkg, sss_step and sss_out_queue.
//
//  channel   dir  tdata (low bit up)            tlast      tuser
//  s_axis    in   in_data[63:0], in_keep[71:64] in_last    split_flag
//  m_axis    out  out_data[63:0], out_keep[71:64] out_last -
//
// One input chunk is taken per cycle while the queue has room; its results land
// in the output queue at the next edge. A chunk that ends a joined segment with
// leftover bytes yields two output chunks, written together, the residue last.
// s_axis_tready_o is high while the three-entry output queue holds at most one
// chunk, so input keeps flowing while one result waits. Reset clears mode, split
// flag and queue pointers; held bytes are written before use.
module split_segment_stitcher_core
  import sss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [DataW+KeepW-1:0] s_axis_tdata_i,  // in_data, in_keep
  input  logic                 s_axis_tlast_i,   // in_last
  input  logic                 s_axis_tuser_i,   // split_flag
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [DataW+KeepW-1:0] m_axis_tdata_o,  // out_data, out_keep
  output logic                 m_axis_tlast_o    // out_last
);

  logic      in_fire;
  logic      room;
  sss_push_t push;
  sss_item_t out_item;

  assign s_axis_tready_o = room;
  assign in_fire         = s_axis_tvalid_i && room;

  sss_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_data_i   (s_axis_tdata_i[DataW-1:0]),
    .in_keep_i   (s_axis_tdata_i[DataW+KeepW-1:DataW]),
    .in_last_i   (s_axis_tlast_i),
    .split_flag_i(s_axis_tuser_i),
    .push_o      (push)
  );

  sss_out_queue u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_item_o (out_item)
  );

  assign m_axis_tdata_o = {out_item.keep, out_item.data};
  assign m_axis_tlast_o = out_item.last;

endmodule

// ===== dv/sss_stitch_monitor.sv =====
// Stream monitor for the split segment stitcher: predicts the stitched chunks.
// Watches both stream channels and compares each output transfer in order.
// Depends on sss_pkg for the item type, the widths and the mode codes.
module sss_stitch_monitor
  import sss_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [DataW+KeepW-1:0] in_tdata_i,   // in_data, in_keep
  input  logic                   in_tlast_i,   // in_last
  input  logic                   in_tuser_i,   // split_flag
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [DataW+KeepW-1:0] out_tdata_i,  // out_data, out_keep
  input  logic                   out_tlast_i,  // out_last
  output int                     errors_o,
  output int                     outstanding_o
);

  sss_mode_e        mode_q;
  logic             join_q;
  logic [DataW-1:0] held_data_q;
  logic [KeepW-1:0] held_keep_q;
  int unsigned      held_n_q;
  sss_item_t        stitched_q[$];
  sss_item_t        oldest;
  int               err_cnt = 0;

  assign errors_o = err_cnt;

  task automatic push_chunk(input logic [DataW-1:0] data, input logic [KeepW-1:0] keep,
                            input logic last);
    sss_item_t item;
    item.data = data;
    item.keep = keep;
    item.last = last;
    stitched_q.push_back(item);
  endtask

  task automatic stitch_chunk(input logic [DataW-1:0] data, input logic [KeepW-1:0] keep,
                              input logic last, input logic split);
    int unsigned      n;
    int unsigned      c;
    logic [KeepW-1:0] bmask;
    logic [KeepW-1:0] jk;
    logic [DataW-1:0] dmask;
    logic [DataW-1:0] jd;
    logic             fits;
    // the split flag only counts on the first chunk of a segment
    if (mode_q == MODE_IDLE) join_q = split;
    case (mode_q)
      MODE_IDLE, MODE_FWD1: begin
        if (!last) begin
          push_chunk(data, keep, 1'b0);
          mode_q = MODE_FWD1;
        end else if (!join_q) begin
          push_chunk(data, keep, 1'b1);
          mode_q = MODE_IDLE;
        end else begin
          n = $countones(keep);
          if (n == 0 || n == KeepW) begin
            // aligned or empty end of the first piece: forward, clear last
            push_chunk(data, keep, 1'b0);
            mode_q = MODE_FWD2;
          end else begin
            held_data_q = data;
            held_keep_q = keep;
            held_n_q    = n;
            mode_q      = MODE_JOIN;
          end
        end
      end
      MODE_FWD2: begin
        push_chunk(data, keep, last);
        if (last) mode_q = MODE_IDLE;
      end
      MODE_JOIN: begin
        c = (held_n_q % KeepW == 0) ? 1 : held_n_q % KeepW;
        bmask = KeepW'((1 << c) - 1);
        dmask = (64'd1 << (8 * c)) - 64'd1;
        jd    = (held_data_q & dmask) | (data << (8 * c));
        jk    = (held_keep_q & bmask) | KeepW'(keep << c);
        fits  = (keep[KeepW-c] == 1'b0);
        held_data_q = data >> (DataW - 8 * c);
        held_keep_q = (keep >> (KeepW - c)) & bmask;
        if (fits) begin
          // the shifted bytes fit: this chunk closes the segment
          push_chunk(jd, jk, 1'b1);
          mode_q = MODE_IDLE;
        end else begin
          push_chunk(jd, jk, 1'b0);
          if (last) begin
            push_chunk(held_data_q & dmask, held_keep_q, 1'b1);
            mode_q = MODE_IDLE;
          end
        end
      end
      default: mode_q = MODE_IDLE;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = MODE_IDLE;
      join_q = 1'b0;
      stitched_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (stitched_q.size() == 0) begin
          $error("output transfer with nothing expected: data %h keep %h last %b",
                 out_tdata_i[DataW-1:0], out_tdata_i[DataW+:KeepW], out_tlast_i);
          err_cnt++;
        end else begin
          oldest = stitched_q.pop_front();
          if (out_tdata_i[DataW-1:0] !== oldest.data) begin
            $error("out_data: expected %h, got %h", oldest.data, out_tdata_i[DataW-1:0]);
            err_cnt++;
          end
          if (out_tdata_i[DataW+:KeepW] !== oldest.keep) begin
            $error("out_keep: expected %h, got %h", oldest.keep, out_tdata_i[DataW+:KeepW]);
            err_cnt++;
          end
          if (out_tlast_i !== oldest.last) begin
            $error("out_last: expected %b, got %b", oldest.last, out_tlast_i);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        stitch_chunk(in_tdata_i[DataW-1:0], in_tdata_i[DataW+:KeepW], in_tlast_i, in_tuser_i);
      end
      outstanding_o <= stitched_q.size();
    end
  end

endmodule

// ===== dv/tb_split_segment_stitcher_core.sv =====
// Testbench top for split_segment_stitcher_core: drives segment chunk streams.
// Directed segments first, then random phases with sender gaps and receiver stalls.
// Depends on sss_pkg, the core and sss_stitch_monitor, which does the checking.
module tb_split_segment_stitcher_core
  import sss_pkg::*;
;

  localparam int StallLimit = 2000;
  localparam int PhaseItems = 258;

  logic                   clk;
  logic                   rst_n   = 1'b0;
  logic                   s_valid = 1'b0;
  logic [DataW+KeepW-1:0] s_data  = '0;
  logic                   s_last  = 1'b0;
  logic                   s_user  = 1'b0;
  logic                   s_ready;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [DataW+KeepW-1:0] m_data;
  logic                   m_last;

  int errors;
  int outstanding;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int sent          = 0;
  int quiet_cycles  = 0;

  split_segment_stitcher_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  sss_stitch_monitor u_monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (s_valid),
    .in_ready_i    (s_ready),
    .in_tdata_i    (s_data),
    .in_tlast_i    (s_last),
    .in_tuser_i    (s_user),
    .out_valid_i   (m_valid),
    .out_ready_i   (m_ready),
    .out_tdata_i   (m_data),
    .out_tlast_i   (m_last),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // end the run when no transfer happens on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [KeepW-1:0] keep_of(input int unsigned len);
    return KeepW'((9'd1 << len) - 9'd1);
  endfunction

  function automatic logic [DataW-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // Present one chunk and hold it until the transfer happens
  task automatic send_chunk(input logic [DataW-1:0] data, input logic [KeepW-1:0] keep,
                            input logic last, input logic split);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {keep, data};
    s_last  <= last;
    s_user  <= split;
    do @(posedge clk); while (!s_ready);
    sent++;
  endtask

  // Hold the sender off until every predicted chunk has been seen
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_piece(input int unsigned chunks, input int unsigned end_len,
                            input logic split);
    logic [KeepW-1:0] keep;
    for (int unsigned i = 1; i < chunks; i++) begin
      keep = ($urandom_range(0, 9) == 0) ? KeepW'($urandom) : {KeepW{1'b1}};
      send_chunk(rand_data(), keep, 1'b0, (i == 1) ? split : 1'($urandom));
    end
    keep = ($urandom_range(0, 9) == 0) ? KeepW'($urandom) : keep_of(end_len);
    send_chunk(rand_data(), keep, 1'b1, (chunks == 1) ? split : 1'($urandom));
  endtask

  task automatic send_random_segment();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // noise: anything goes
      send_chunk(rand_data(), KeepW'($urandom), 1'($urandom), 1'($urandom));
    end else if (kind < 40) begin
      send_piece($urandom_range(1, 4), $urandom_range(1, 8), 1'b0);
    end else begin
      send_piece($urandom_range(1, 3), $urandom_range(0, 8), 1'b1);
      send_piece($urandom_range(1, 3), $urandom_range(1, 8), 1'($urandom));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int target;
    snd_idle_pct  = idle_pct;
    rcv_stall_pct = stall_pct;
    target = sent + PhaseItems;
    while (sent < target) send_random_segment();
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unsplit segments, data extremes
    send_chunk({DataW{1'b0}}, keep_of(8), 1'b1, 1'b0);
    send_chunk({DataW{1'b1}}, keep_of(1), 1'b1, 1'b0);
    send_chunk(rand_data(), keep_of(8), 1'b0, 1'b0);
    send_chunk(rand_data(), keep_of(7), 1'b1, 1'b1);
    // aligned split, then second piece passes through
    send_chunk({DataW{1'b1}}, keep_of(8), 1'b1, 1'b1);
    send_chunk(rand_data(), keep_of(8), 1'b0, 1'b0);
    send_chunk(rand_data(), keep_of(2), 1'b1, 1'b0);
    // empty end of the first piece
    send_chunk(rand_data(), keep_of(0), 1'b1, 1'b1);
    send_chunk(rand_data(), keep_of(4), 1'b1, 1'b0);
    // join with a residue chunk
    send_chunk(rand_data(), keep_of(3), 1'b1, 1'b1);
    send_chunk(rand_data(), keep_of(8), 1'b0, 1'b0);
    send_chunk({DataW{1'b1}}, keep_of(8), 1'b1, 1'b1);
    // early fit before the second piece ends
    send_chunk(rand_data(), keep_of(6), 1'b1, 1'b1);
    send_chunk(rand_data(), keep_of(2), 1'b0, 1'b0);
    // non-contiguous keep on both pieces
    send_chunk(rand_data(), 8'hA5, 1'b1, 1'b1);
    send_chunk(rand_data(), 8'h5A, 1'b1, 1'b0);
    // smallest and largest held counts
    send_chunk(rand_data(), keep_of(1), 1'b1, 1'b1);
    send_chunk(rand_data(), keep_of(8), 1'b1, 1'b0);
    send_chunk(rand_data(), keep_of(7), 1'b1, 1'b1);
    send_chunk(rand_data(), keep_of(1), 1'b1, 1'b0);
    send_chunk(rand_data(), keep_of(7), 1'b1, 1'b1);
    send_chunk(rand_data(), keep_of(8), 1'b1, 1'b0);
    drain();

    run_phase(0, 0);
    run_phase(58, 0);
    run_phase(0, 58);
    run_phase(29, 29);

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sss_pkg.sv
hw/rtl/sss_step.sv
hw/rtl/sss_out_queue.sv
hw/rtl/split_segment_stitcher_core.sv
dv/sss_stitch_monitor.sv
dv/tb_split_segment_stitcher_core.sv
